@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the parser modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ rtl/core/cclp_pkg.sv @@
// ----------------------------------------------------------------------------
// Command line parser package
// Shared types and character constants for the command line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cclp_pkg;

    // Queue between the classifier and the parser.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Characters of interest.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Operand magnitude limits: 2^30 and the saturation cap 2^30 + 1.
    localparam logic [30:0] MAG_LIMIT = 31'h4000_0000;
    localparam logic [30:0] MAG_CAP   = 31'h4000_0001;

    // Token counter saturates here.
    localparam logic [2:0] TOK_SAT = 3'd4;
    localparam logic [2:0] TOK_OP  = 3'd1;
    localparam logic [2:0] TOK_A   = 3'd2;
    localparam logic [2:0] TOK_B   = 3'd3;

    // One classified word travelling from the front to the back.
    typedef struct packed {
        logic       eol;
        logic [7:0] ch;
        logic       is_space;
        logic       is_digit;
        logic       is_sign;
        logic       is_minus;
        logic       is_op;
        logic [3:0] digit;
    } item_t;

    // One parse result.
    typedef struct packed {
        logic               line_valid;
        logic [7:0]         op_char;
        logic signed [30:0] first_operand;
        logic signed [30:0] second_operand;
        logic [2:0]         tokens_seen;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/cclp_front.sv @@
// ----------------------------------------------------------------------------
// Command line parser front end
// Classifies each incoming character into flags and a digit value for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module cclp_front (
    input  wire logic          req_type,
    input  wire logic [7:0]    ch,
    output cclp_pkg::item_t    item
);

    logic [7:0] digit_wide;

    // Character classes and the digit value.
    always_comb
    begin
        digit_wide    = ch - cclp_pkg::CH_ZERO;
        item.eol      = req_type;
        item.ch       = ch;
        item.is_space = (ch == cclp_pkg::CH_SPACE);
        item.is_digit = (ch >= cclp_pkg::CH_ZERO) && (ch <= cclp_pkg::CH_NINE);
        item.is_sign  = (ch == cclp_pkg::CH_PLUS) || (ch == cclp_pkg::CH_MINUS);
        item.is_minus = (ch == cclp_pkg::CH_MINUS);
        item.is_op    = (ch == cclp_pkg::CH_EQ) || (ch == cclp_pkg::CH_X)
                     || (ch == cclp_pkg::CH_PLUS) || (ch == cclp_pkg::CH_SLASH)
                     || (ch == cclp_pkg::CH_MINUS);
        item.digit    = digit_wide[3:0];
    end

endmodule

`default_nettype wire

@@ rtl/core/cclp_queue.sv @@
// ----------------------------------------------------------------------------
// Command line parser queue
// Short first-in first-out buffer between the classifier and the parser.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cclp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire cclp_pkg::item_t   push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   valid,
    output cclp_pkg::item_t        head
);

    cclp_pkg::item_t                  slot_reg [cclp_pkg::QUEUE_DEPTH];
    logic [cclp_pkg::PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [cclp_pkg::PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [cclp_pkg::CNT_W-1:0]       count_reg, count_next;

    localparam logic [cclp_pkg::CNT_W-1:0] FULL_COUNT =
        cclp_pkg::CNT_W'(cclp_pkg::QUEUE_DEPTH);

    assign full  = (count_reg == FULL_COUNT);
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Checks.
    `ASSERT_NEVER(a_no_overfill, count_reg > FULL_COUNT, "queue count beyond depth")
    `ASSERT_NEVER(a_no_push_full, push && full, "push into a full queue")
    `ASSERT_NEVER(a_no_pop_empty, pop && !valid, "pop from an empty queue")
    `ASSERT_CLK(a_count_track, push && !pop |=> count_reg == $past(count_reg) + 1'b1,
        "queue count did not follow a push")

endmodule

`default_nettype wire

@@ rtl/core/cclp_back.sv @@
// ----------------------------------------------------------------------------
// Command line parser back end
// Tracks tokens, accumulates operands and holds the result for the output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cclp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire cclp_pkg::item_t   item,
    output logic                   pop,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output cclp_pkg::result_t      res
);

    // Per-line parse state.
    logic [2:0]         tok_cnt_reg, tok_cnt_next;
    logic               inside_reg, inside_next;
    logic               chars_reg, chars_next;
    logic               neg_reg, neg_next;
    logic               stopped_reg, stopped_next;
    logic [30:0]        mag_reg, mag_next;
    logic               bad_reg, bad_next;
    logic [7:0]         op_reg, op_next;
    logic [30:0]        first_reg, first_next;
    logic [30:0]        second_reg, second_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    cclp_pkg::result_t  out_reg, out_next;

    // Helper terms.
    logic [34:0]        acc_wide;
    logic [30:0]        acc_sat;
    logic [30:0]        close_mag;
    logic [30:0]        close_val;
    logic               close_bad;
    logic               operand_tok;
    logic [2:0]         tok_new;
    logic               bad_fin;
    logic [30:0]        first_fin;
    logic [30:0]        second_fin;

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // An end-of-line word waits for a free output slot; characters never wait.
    assign pop = item_valid && (!item.eol || !out_valid_reg || res_ready);

    // Decimal accumulate with saturation at the cap.
    always_comb
    begin
        acc_wide = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1)
                 + {31'b0, item.digit};
        acc_sat  = (acc_wide > {4'b0, cclp_pkg::MAG_CAP}) ? cclp_pkg::MAG_CAP
                                                         : acc_wide[30:0];
    end

    // Range check and two's complement of a closing operand.
    always_comb
    begin
        operand_tok = (tok_cnt_reg == cclp_pkg::TOK_A) || (tok_cnt_reg == cclp_pkg::TOK_B);
        if (neg_reg)
        begin
            close_bad = stopped_reg || (mag_reg > cclp_pkg::MAG_LIMIT);
            close_mag = (mag_reg > cclp_pkg::MAG_LIMIT) ? cclp_pkg::MAG_LIMIT : mag_reg;
            close_val = ~close_mag + 31'd1;
        end
        else
        begin
            close_bad = stopped_reg || (mag_reg >= cclp_pkg::MAG_LIMIT);
            close_mag = mag_reg;
            close_val = (mag_reg >= cclp_pkg::MAG_LIMIT) ? cclp_pkg::MAG_LIMIT - 31'd1
                                                        : mag_reg;
        end
    end

    // Line values once an open token at end of line is closed.
    always_comb
    begin
        bad_fin    = bad_reg || (inside_reg && operand_tok && close_bad);
        first_fin  = (inside_reg && tok_cnt_reg == cclp_pkg::TOK_A) ? close_val : first_reg;
        second_fin = (inside_reg && tok_cnt_reg == cclp_pkg::TOK_B) ? close_val : second_reg;
        tok_new    = tok_cnt_reg;
        if (!inside_reg && tok_cnt_reg < cclp_pkg::TOK_SAT)
        begin
            tok_new = tok_cnt_reg + 3'd1;
        end
    end

    // Parse state update.
    always_comb
    begin
        tok_cnt_next = tok_cnt_reg;
        inside_next  = inside_reg;
        chars_next   = chars_reg;
        neg_next     = neg_reg;
        stopped_next = stopped_reg;
        mag_next     = mag_reg;
        bad_next     = bad_reg;
        op_next      = op_reg;
        first_next   = first_reg;
        second_next  = second_reg;

        if (pop)
        begin
            priority if (item.eol)
            begin
                tok_cnt_next = '0;
                inside_next  = 1'b0;
                chars_next   = 1'b0;
                neg_next     = 1'b0;
                stopped_next = 1'b0;
                mag_next     = '0;
                bad_next     = 1'b0;
                op_next      = '0;
                first_next   = '0;
                second_next  = '0;
            end
            else if (item.is_space)
            begin
                if (inside_reg)
                begin
                    if (operand_tok)
                    begin
                        bad_next = bad_reg || close_bad;
                        if (tok_cnt_reg == cclp_pkg::TOK_A)
                        begin
                            first_next = close_val;
                        end
                        else
                        begin
                            second_next = close_val;
                        end
                    end
                    inside_next  = 1'b0;
                    chars_next   = 1'b0;
                    neg_next     = 1'b0;
                    stopped_next = 1'b0;
                    mag_next     = '0;
                end
            end
            else
            begin
                inside_next  = 1'b1;
                tok_cnt_next = tok_new;
                chars_next   = 1'b1;
                // First character of the operator token.
                if (!inside_reg && tok_new == cclp_pkg::TOK_OP)
                begin
                    op_next = item.ch;
                    if (!item.is_op)
                    begin
                        bad_next = 1'b1;
                    end
                end
                // Operand tokens: digits, a leading sign, or a stop.
                if (tok_new == cclp_pkg::TOK_SAT)
                begin
                    bad_next = 1'b1;
                end
                else if (tok_new != cclp_pkg::TOK_OP)
                begin
                    priority if (item.is_digit)
                    begin
                        if (!stopped_reg)
                        begin
                            mag_next = acc_sat;
                        end
                    end
                    else if (item.is_sign && !chars_reg)
                    begin
                        neg_next = item.is_minus;
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
            end
        end
    end

    // Output register: loads at end of line, empties when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        if (pop && item.eol)
        begin
            out_valid_next          = 1'b1;
            out_next.line_valid     = !bad_fin && (tok_cnt_reg == cclp_pkg::TOK_OP
                                                || tok_cnt_reg == cclp_pkg::TOK_B);
            out_next.op_char        = op_reg;
            out_next.first_operand  = first_fin;
            out_next.second_operand = second_fin;
            out_next.tokens_seen    = tok_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_cnt_reg   <= '0;
            inside_reg    <= 1'b0;
            chars_reg     <= 1'b0;
            neg_reg       <= 1'b0;
            stopped_reg   <= 1'b0;
            mag_reg       <= '0;
            bad_reg       <= 1'b0;
            op_reg        <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tok_cnt_reg   <= tok_cnt_next;
            inside_reg    <= inside_next;
            chars_reg     <= chars_next;
            neg_reg       <= neg_next;
            stopped_reg   <= stopped_next;
            mag_reg       <= mag_next;
            bad_reg       <= bad_next;
            op_reg        <= op_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Checks.
    `ASSERT_NEVER(a_tok_sat, tok_cnt_reg > cclp_pkg::TOK_SAT, "token count beyond saturation")
    `ASSERT_NEVER(a_mag_cap, mag_reg > cclp_pkg::MAG_CAP, "magnitude beyond cap")
    `ASSERT_CLK(a_valid_count, out_valid_reg && out_reg.line_valid |->
        out_reg.tokens_seen == cclp_pkg::TOK_OP || out_reg.tokens_seen == cclp_pkg::TOK_B,
        "valid line with wrong token count")
    `ASSERT_CLK(a_line_cleared, pop && item.eol |=> tok_cnt_reg == '0 && !inside_reg,
        "line state not cleared after end of line")

endmodule

`default_nettype wire

@@ rtl/core/calc_command_line_parser_top.sv @@
// ----------------------------------------------------------------------------
// Command line parser top level
// Checks and parses an operator and two decimal operands from a text line.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata                                   | tuser
//  s_axis  | in        | ch[7:0]                                 | req_type
//  m_axis  | out       | op_char, first_operand, second_operand, | line_valid
//          |           | tokens_seen (bits 72:0, zero padded)    |
//
//  One word is accepted per cycle while the four-word queue has room.
//  The parser drains one word per cycle; an end-of-line word waits only for
//  the output register, which loads the line's result as that word is popped
//  from the queue.
//  Reset (rst_n low) clears the queue, the line state and the output valid.
//  A stalled output holds the result; the queue absorbs up to four words.
//
`default_nettype none

module calc_command_line_parser_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] ch
    input  wire logic         s_tuser,   // [0] req_type
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [79:0]       m_tdata,   // [7:0] op_char, [38:8] first_operand,
                                         // [69:39] second_operand, [72:70] tokens_seen
    output logic              m_tuser    // [0] line_valid
);

    cclp_pkg::item_t    front_item;
    cclp_pkg::item_t    head_item;
    cclp_pkg::result_t  result;
    logic               queue_full;
    logic               queue_valid;
    logic               queue_pop;
    logic               push;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    // Classifier.
    cclp_front u_front (
        .req_type (s_tuser),
        .ch       (s_tdata),
        .item     (front_item)
    );

    // Queue between classifier and parser.
    cclp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .valid     (queue_valid),
        .head      (head_item)
    );

    // Parser and output register.
    cclp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_valid),
        .item       (head_item),
        .pop        (queue_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (result)
    );

    // Output packing.
    assign m_tuser = result.line_valid;
    assign m_tdata = {7'b0, result.tokens_seen, result.second_operand,
                      result.first_operand, result.op_char};

endmodule

`default_nettype wire

@@ bench/tb_calc_command_line_parser_top.sv @@
// ----------------------------------------------------------------------------
// Command line parser testbench
// Sends command lines one character word at a time and checks every parse
// result against an in-bench line parser or a result typed in the table of
// directed lines, which come first; random, mostly well formed lines follow.
// Both stream sides idle at random, the output side also holds off for a
// long stretch once, and the sender pauses for the results to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_calc_command_line_parser_top;

    // Word kinds on the input tuser.
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_EOL  = 1'b1;

    localparam int RESET_CYCLES = 8;
    localparam int ITEM_TARGET  = 1300;
    localparam int QUIET_ITEMS  = 150;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DIR_ROWS     = 28;

    localparam cclp_pkg::result_t NO_RES = '0;

    // One row of the directed table.
    typedef struct {
        logic              req;
        logic [7:0]        ch;
        bit                typed;
        cclp_pkg::result_t want;
    } row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;

    // Expected parse results, oldest first.
    cclp_pkg::result_t expected_lines [$];
    int          err_cnt     = 0;
    int          sent_items  = 0;
    int          cycle_cnt   = 0;
    bit          quiet       = 1'b0;
    bit          hold_req    = 1'b0;
    logic [7:0]  line_buf [$];
    row_t        dir_rows [DIR_ROWS];
    logic [7:0]  op_set [5] = '{cclp_pkg::CH_EQ, cclp_pkg::CH_X, cclp_pkg::CH_PLUS,
                                cclp_pkg::CH_SLASH, cclp_pkg::CH_MINUS};

    // Line parser state.
    logic [2:0]  tok_count;
    logic        in_tok;
    logic        tok_begun;
    logic        tok_neg;
    logic [30:0] tok_mag;
    logic        tok_halted;
    logic        line_rejected;
    logic [7:0]  op_held;
    logic [30:0] opnd_a;
    logic [30:0] opnd_b;

    calc_command_line_parser_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Run time guard.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb_calc_command_line_parser_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Line parser
    // ------------------------------------------------------------------

    function automatic bit is_op_char(logic [7:0] c);
        return c == cclp_pkg::CH_EQ || c == cclp_pkg::CH_X || c == cclp_pkg::CH_PLUS
            || c == cclp_pkg::CH_SLASH || c == cclp_pkg::CH_MINUS;
    endfunction

    function automatic void clear_line_state();
        tok_count     = '0;
        in_tok        = 1'b0;
        tok_begun     = 1'b0;
        tok_neg       = 1'b0;
        tok_mag       = '0;
        tok_halted    = 1'b0;
        line_rejected = 1'b0;
        op_held       = '0;
        opnd_a        = '0;
        opnd_b        = '0;
    endfunction

    // Range check an operand token and store it as 31-bit two's complement.
    function automatic void close_operand();
        logic [30:0] val;
        bit          reject;
        reject = tok_halted;
        if (tok_count == cclp_pkg::TOK_A || tok_count == cclp_pkg::TOK_B)
        begin
            if (tok_neg)
            begin
                if (tok_mag > cclp_pkg::MAG_LIMIT)
                begin
                    reject = 1'b1;
                    val    = cclp_pkg::MAG_LIMIT;
                end
                else
                    val = tok_mag;
                val = 31'd0 - val;
            end
            else if (tok_mag > cclp_pkg::MAG_LIMIT - 31'd1)
            begin
                reject = 1'b1;
                val    = cclp_pkg::MAG_LIMIT - 31'd1;
            end
            else
                val = tok_mag;
            if (reject)
                line_rejected = 1'b1;
            if (tok_count == cclp_pkg::TOK_A)
                opnd_a = val;
            else
                opnd_b = val;
        end
        in_tok     = 1'b0;
        tok_begun  = 1'b0;
        tok_neg    = 1'b0;
        tok_mag    = '0;
        tok_halted = 1'b0;
    endfunction

    function automatic void parse_char(logic [7:0] c);
        logic [63:0] grown;
        if (c == cclp_pkg::CH_SPACE)
        begin
            if (in_tok)
                close_operand();
            return;
        end
        if (!in_tok)
        begin
            in_tok = 1'b1;
            if (tok_count < cclp_pkg::TOK_SAT)
                tok_count = tok_count + 3'd1;
            if (tok_count == cclp_pkg::TOK_OP)
            begin
                op_held = c;
                if (!is_op_char(c))
                    line_rejected = 1'b1;
            end
        end
        // The operator token only keeps its first character.
        if (tok_count == cclp_pkg::TOK_OP)
        begin
            tok_begun = 1'b1;
            return;
        end
        // Any fourth token spoils the line.
        if (tok_count > cclp_pkg::TOK_B)
        begin
            tok_begun     = 1'b1;
            line_rejected = 1'b1;
            return;
        end
        if (c >= cclp_pkg::CH_ZERO && c <= cclp_pkg::CH_NINE)
        begin
            if (!tok_halted)
            begin
                grown   = 64'(tok_mag) * 64'd10 + 64'(c - cclp_pkg::CH_ZERO);
                tok_mag = (grown > 64'(cclp_pkg::MAG_CAP)) ? cclp_pkg::MAG_CAP
                                                           : grown[30:0];
            end
        end
        else if ((c == cclp_pkg::CH_PLUS || c == cclp_pkg::CH_MINUS) && !tok_begun)
            tok_neg = (c == cclp_pkg::CH_MINUS);
        else
            tok_halted = 1'b1;
        tok_begun = 1'b1;
    endfunction

    function automatic cclp_pkg::result_t finish_line();
        cclp_pkg::result_t r;
        if (in_tok)
            close_operand();
        r.line_valid     = !line_rejected && (tok_count == cclp_pkg::TOK_OP
                                              || tok_count == cclp_pkg::TOK_B);
        r.op_char        = op_held;
        r.first_operand  = opnd_a;
        r.second_operand = opnd_b;
        r.tokens_seen    = tok_count;
        clear_line_state();
        return r;
    endfunction

    function automatic cclp_pkg::result_t line_res(logic v, logic [7:0] op, int a, int b,
                                                   int n);
        cclp_pkg::result_t r;
        r.line_valid     = v;
        r.op_char        = op;
        r.first_operand  = a[30:0];
        r.second_operand = b[30:0];
        r.tokens_seen    = n[2:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_err(string msg);
        $display("%0t ERROR: %s", $time, msg);
        err_cnt++;
    endtask

    // Compare the word on the output with the oldest expected result.
    task automatic check_line_result();
        cclp_pkg::result_t got;
        cclp_pkg::result_t want;
        got.line_valid     = m_tuser;
        got.op_char        = m_tdata[7:0];
        got.first_operand  = m_tdata[38:8];
        got.second_operand = m_tdata[69:39];
        got.tokens_seen    = m_tdata[72:70];
        if (expected_lines.size() == 0)
        begin
            report_err("result word with no line pending");
            return;
        end
        want = expected_lines.pop_front();
        if (got.line_valid != want.line_valid)
            report_err($sformatf("line_valid got %0d expected %0d",
                                 got.line_valid, want.line_valid));
        if (got.op_char != want.op_char)
            report_err($sformatf("op_char got %02h expected %02h",
                                 got.op_char, want.op_char));
        if (got.first_operand != want.first_operand)
            report_err($sformatf("first_operand got %0d expected %0d",
                                 got.first_operand, want.first_operand));
        if (got.second_operand != want.second_operand)
            report_err($sformatf("second_operand got %0d expected %0d",
                                 got.second_operand, want.second_operand));
        if (got.tokens_seen != want.tokens_seen)
            report_err($sformatf("tokens_seen got %0d expected %0d",
                                 got.tokens_seen, want.tokens_seen));
    endtask

    // Output side: random stalls, one long hold-off on request.
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_line_result();
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one word and wait until it is taken; the parser follows it.
    task automatic send_word(logic req, logic [7:0] c, bit typed, cclp_pkg::result_t want);
        cclp_pkg::result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (req == REQ_EOL)
        begin
            r = finish_line();
            expected_lines.push_back(typed ? want : r);
        end
        else
            parse_char(c);
        sent_items++;
        quiet = (sent_items >= ITEM_TARGET - QUIET_ITEMS);
    endtask

    // Random idle burst on the input side; rate 0 means none.
    task automatic idle_gap(int rate);
        if (!quiet && rate != 0 && $urandom_range(0, rate - 1) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(posedge clk);
        end
    endtask

    // Stop offering until every pending line has its result.
    task automatic drain_pause();
        s_tvalid <= 1'b0;
        wait (expected_lines.size() == 0);
        @(posedge clk);
    endtask

    function automatic void push_spaces(int n);
        repeat (n)
            line_buf.push_back(cclp_pkg::CH_SPACE);
    endfunction

    function automatic void push_num(longint v, bit plus, int zeros);
        longint unsigned mag;
        logic [7:0]      digs [$];
        if (v < 0)
        begin
            line_buf.push_back(cclp_pkg::CH_MINUS);
            mag = -v;
        end
        else
        begin
            if (plus)
                line_buf.push_back(cclp_pkg::CH_PLUS);
            mag = v;
        end
        repeat (zeros)
            line_buf.push_back(cclp_pkg::CH_ZERO);
        do
        begin
            digs.push_front(8'(mag % 10) + cclp_pkg::CH_ZERO);
            mag = mag / 10;
        end
        while (mag != 0);
        foreach (digs[i])
            line_buf.push_back(digs[i]);
    endfunction

    // Operand values: mostly small, some full range, bounds and overflow.
    function automatic longint pick_operand();
        longint          bounds [5];
        longint unsigned big;
        int              k;
        bounds = '{longint'(1073741823), -longint'(1073741824), longint'(1073741824),
                   -longint'(1073741825), longint'(0)};
        k = $urandom_range(0, 99);
        if (k < 50)
            return longint'($urandom_range(0, 1998)) - 999;
        if (k < 70)
            return longint'($urandom & 32'h7FFF_FFFF) - longint'(1073741824);
        if (k < 85)
            return bounds[$urandom_range(0, 4)];
        big = ({$urandom, $urandom} % 64'd9_000_000_000_000) + 64'd1_073_741_824;
        return $urandom_range(0, 1) ? -longint'(big) : longint'(big);
    endfunction

    // Build one random command line into line_buf.
    task automatic build_line();
        int ntok;
        int k;
        line_buf.delete();
        // Pure noise line.
        if ($urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(1, 12))
                line_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        k = $urandom_range(0, 99);
        if (k < 25)
            ntok = 1;
        else if (k < 70)
            ntok = 3;
        else if (k < 80)
            ntok = 2;
        else if (k < 90)
            ntok = 4 + $urandom_range(0, 1);
        else
            ntok = 0;
        if ($urandom_range(0, 4) == 0)
            push_spaces($urandom_range(1, 3));
        for (int t = 0; t < ntok; t++)
        begin
            if (t > 0)
                push_spaces(($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1);
            if (t == 0)
            begin
                if ($urandom_range(0, 9) != 0)
                    line_buf.push_back(op_set[$urandom_range(0, 4)]);
                else
                    line_buf.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        line_buf.push_back(8'($urandom_range(33, 126)));
            end
            else if ($urandom_range(0, 19) == 0)
                line_buf.push_back($urandom_range(0, 1) ? cclp_pkg::CH_PLUS
                                                        : cclp_pkg::CH_MINUS);
            else
                push_num(pick_operand(), $urandom_range(0, 3) == 0,
                         ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
        end
        if ($urandom_range(0, 4) == 0)
            push_spaces($urandom_range(1, 3));
        // Occasionally break the line with a stray byte.
        if ($urandom_range(0, 9) == 0)
            line_buf.insert($urandom_range(0, line_buf.size()), 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int line_no;
        int gap_rate;

        clear_line_state();
        dir_rows = '{
            // Empty line right after reset.
            '{REQ_EOL,  8'h00,              1'b1, line_res(1'b0, 8'h00, 0, 0, 0)},
            // Operator alone.
            '{REQ_CHAR, cclp_pkg::CH_EQ,    1'b0, NO_RES},
            '{REQ_EOL,  8'h00,              1'b1, line_res(1'b1, cclp_pkg::CH_EQ, 0, 0, 1)},
            // Lone signs as operands.
            '{REQ_CHAR, cclp_pkg::CH_PLUS,  1'b0, NO_RES},
            '{REQ_CHAR, cclp_pkg::CH_SPACE, 1'b0, NO_RES},
            '{REQ_CHAR, cclp_pkg::CH_MINUS, 1'b0, NO_RES},
            '{REQ_CHAR, cclp_pkg::CH_SPACE, 1'b0, NO_RES},
            '{REQ_CHAR, cclp_pkg::CH_PLUS,  1'b0, NO_RES},
            '{REQ_EOL,  8'h00,              1'b1, line_res(1'b1, cclp_pkg::CH_PLUS, 0, 0, 3)},
            // Run of spaces, then a sign after a digit stops the parse.
            '{REQ_CHAR, cclp_pkg::CH_X,     1'b0, NO_RES},
            '{REQ_CHAR, cclp_pkg::CH_SPACE, 1'b0, NO_RES},
            '{REQ_CHAR, cclp_pkg::CH_SPACE, 1'b0, NO_RES},
            '{REQ_CHAR, "2",                1'b0, NO_RES},
            '{REQ_CHAR, cclp_pkg::CH_MINUS, 1'b0, NO_RES},
            '{REQ_EOL,  8'h00,              1'b0, NO_RES},
            // Zero character and all-ones character inside an operand.
            '{REQ_CHAR, cclp_pkg::CH_SLASH, 1'b0, NO_RES},
            '{REQ_CHAR, cclp_pkg::CH_SPACE, 1'b0, NO_RES},
            '{REQ_CHAR, 8'h00,              1'b0, NO_RES},
            '{REQ_CHAR, 8'hFF,              1'b0, NO_RES},
            '{REQ_EOL,  8'h00,              1'b1, line_res(1'b0, cclp_pkg::CH_SLASH, 0, 0, 2)},
            // A fourth token is counted but not stored.
            '{REQ_CHAR, cclp_pkg::CH_MINUS, 1'b0, NO_RES},
            '{REQ_CHAR, cclp_pkg::CH_SPACE, 1'b0, NO_RES},
            '{REQ_CHAR, "1",                1'b0, NO_RES},
            '{REQ_CHAR, cclp_pkg::CH_SPACE, 1'b0, NO_RES},
            '{REQ_CHAR, "2",                1'b0, NO_RES},
            '{REQ_CHAR, cclp_pkg::CH_SPACE, 1'b0, NO_RES},
            '{REQ_CHAR, "3",                1'b0, NO_RES},
            '{REQ_EOL,  8'h00,              1'b1, line_res(1'b0, cclp_pkg::CH_MINUS, 1, 2, 4)}
        };

        // Reset once at the start.
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (dir_rows[i])
        begin
            idle_gap(4);
            send_word(dir_rows[i].req, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);
        end
        drain_pause();

        // Random lines.
        line_no = 0;
        while (sent_items < ITEM_TARGET)
        begin
            build_line();
            if (line_no == 4)
                hold_req = 1'b1;
            if (line_no == 30)
                drain_pause();
            gap_rate = ($urandom_range(0, 2) == 0) ? 0 : 6;
            foreach (line_buf[i])
            begin
                idle_gap(gap_rate);
                send_word(REQ_CHAR, line_buf[i], 1'b0, NO_RES);
            end
            idle_gap(gap_rate);
            send_word(REQ_EOL, 8'($urandom_range(0, 255)), 1'b0, NO_RES);
            line_no++;
        end
        s_tvalid <= 1'b0;

        // Let the last results come out.
        wait (expected_lines.size() == 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (err_cnt == 0)
            $display("tb_calc_command_line_parser_top: clean");
        else
            $display("tb_calc_command_line_parser_top: errors");
        $finish;
    end

endmodule
